// ===== rtl/core/chebyshev_series_evaluator_assert.svh =====
// Assertion macros shared by the checker files of the Chebyshev series evaluator.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef CHEBYSHEV_SERIES_EVALUATOR_ASSERT_SVH
`define CHEBYSHEV_SERIES_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define CSE_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define CSE_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/cse_pkg.sv =====
// Package of the Chebyshev series evaluator: fixed widths, codes and state type.
// Used by the top level and its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

    // Fixed field and datapath widths.
    localparam int IDX_W      = 7;   // coef_index field
    localparam int RECUR_W    = 40;  // Clenshaw accumulators, Q24.15
    localparam int OUT_W      = 24;  // sample_out, Q8.15
    localparam int M_DATA_W   = ((OUT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;

    // Fixed-point scaling.
    localparam int COEF_SHIFT = 3;   // Q3.12 coefficient to Q.15
    localparam int STEP_SHIFT = 14;  // 2*x*b from Q.30 to Q.15
    localparam int STEP_RND   = 1 << (STEP_SHIFT - 1);
    localparam int OUT_SHIFT  = 15;  // x*b from Q.30 to Q.15
    localparam int OUT_RND    = 1 << (OUT_SHIFT - 1);

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASIS_MODE     = 4'd1;

    // Basis modes and reset values.
    localparam logic BASIS_PLAIN = 1'b0;
    localparam logic BASIS_TRIG  = 1'b1;
    localparam logic [CFG_DATA_W-1:0] HARM_COUNT_RST = 7'd16;
    localparam logic BASIS_MODE_RST = BASIS_TRIG;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/cse_coef_ram.sv =====
// Coefficient store: synchronous single-write, single-read memory with a registered read
// port and per-entry valid bits so that unwritten entries read as zero.
`timescale 1ns / 1ps
`default_nettype none

module cse_coef_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Valid bits give the all-zero reset contents without a clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== rtl/core/chebyshev_series_evaluator.sv =====
// Evaluate words: the accepting cycle loads the sample and clears b1 and b2; the Clenshaw
// loop then runs one multiply-accumulate step per harmonic (N = clamped harmonic_count),
// each needing the previous step's b1, and a finish step forms the final x*b1 - b2. No
// input word is taken until the finish step is done; write words are taken at one per
// cycle while idle. A result word stalled at the output holds the final step until taken.
// Reset (synchronous, active low) restores the control and configuration registers and
// marks every coefficient as zero at once through valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module chebyshev_series_evaluator
    import cse_pkg::*;
#(
    parameter int MAX_HARMONICS = 64,
    parameter int COEF_BITS     = 16,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input words.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // s_axis_tdata, lowest bit first: coef_index, coef_value, sample_in, zero padding.
    input  logic [((IDX_W + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // s_axis_tuser: req_type (0 write a coefficient, 1 evaluate a sample).
    input  logic                  s_axis_tuser,
    // Result words.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // m_axis_tdata, lowest bit first: sample_out.
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    // m_axis_tuser: clipped.
    output logic                  m_axis_tuser,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Address of the coefficient store and width of the harmonic counter, which must
    // hold MAX_HARMONICS itself.
    localparam int AW     = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int KW     = $clog2(MAX_HARMONICS + 1);
    // Product of the sample and an accumulator, and the working width of the sums,
    // which is wide enough that neither the rounding add nor the subtraction overflows.
    localparam int PROD_W = RECUR_W + SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + 2;

    // Input fields.
    logic        [IDX_W-1:0]       w_coef_index;
    logic        [COEF_BITS-1:0]   w_coef_value;
    logic signed [SAMPLE_BITS-1:0] w_sample_in;

    assign w_coef_index = s_axis_tdata[IDX_W-1:0];
    assign w_coef_value = s_axis_tdata[IDX_W +: COEF_BITS];
    assign w_sample_in  = s_axis_tdata[IDX_W + COEF_BITS +: SAMPLE_BITS];

    // Configuration registers. Writes must arrive only while the block is idle; the block does
    // not enforce this itself, and the port is always ready. Unknown indexes are dropped.
    logic [CFG_DATA_W-1:0] r_harm_count;
    logic                  r_basis_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harm_count <= HARM_COUNT_RST;
            r_basis_mode <= BASIS_MODE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HARMONIC_COUNT: r_harm_count <= i_cfg_data;
                CFG_BASIS_MODE:     r_basis_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Number of harmonics for the next evaluation; larger counts act as the maximum.
    logic [KW-1:0] w_eval_k;

    always_comb begin
        if (int'(r_harm_count) > MAX_HARMONICS) begin
            w_eval_k = KW'(MAX_HARMONICS);
        end else begin
            w_eval_k = KW'(r_harm_count);
        end
    end

    // Writes to harmonic 0 or beyond the store are dropped.
    logic w_wr_index_ok;

    assign w_wr_index_ok = (w_coef_index != '0) && (int'(w_coef_index) <= MAX_HARMONICS);

    // Sequencer. The store is read one step ahead: the read for harmonic k is issued
    // in the cycle before the step that consumes it, so its registered read is hidden.
    t_state        r_state;
    t_state        n_state;
    logic [KW-1:0] r_k;
    logic          w_s_accept;
    logic          w_mem_we;
    logic          w_load_eval;
    logic          w_step;
    logic          w_finish;
    logic [AW-1:0] w_rd_addr;

    assign w_s_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_mem_we      = 1'b0;
        w_load_eval   = 1'b0;
        w_step        = 1'b0;
        w_finish      = 1'b0;
        w_rd_addr     = '0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_rd_addr     = AW'(w_eval_k - KW'(1));
                if (w_s_accept && (s_axis_tuser == REQ_EVAL)) begin
                    w_load_eval = 1'b1;
                    n_state     = (w_eval_k == '0) ? ST_FINISH : ST_RUN;
                end else if (w_s_accept && (s_axis_tuser == REQ_WRITE)) begin
                    w_mem_we = w_wr_index_ok;
                end
            end
            ST_RUN: begin
                // Fetch harmonic k - 1 while harmonic k is folded in.
                w_step    = 1'b1;
                w_rd_addr = AW'(r_k - KW'(2));
                if (r_k == KW'(1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Wait here while the output register still holds an untaken word.
                if (!m_axis_tvalid || m_axis_tready) begin
                    w_finish = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (w_load_eval) begin
            r_k <= w_eval_k;
        end else if (w_step) begin
            r_k <= r_k - KW'(1);
        end
    end

    // Coefficient store, entry n - 1 holds harmonic n.
    logic [COEF_BITS-1:0] w_rd_data;

    cse_coef_ram #(
        .DEPTH (MAX_HARMONICS),
        .AW    (AW),
        .DW    (COEF_BITS)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (AW'(w_coef_index - IDX_W'(1))),
        .i_wr_data (w_coef_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Datapath. One multiplier, x * b1, serves both the recurrence steps and the
    // final output step.
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [RECUR_W-1:0]     r_b1;
    logic signed [RECUR_W-1:0]     r_b2;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [SUM_W-1:0]       w_prod_ext;
    logic signed [SUM_W-1:0]       w_coef_ext;
    logic signed [SUM_W-1:0]       w_coef_q15;
    logic                          w_flip;
    logic signed [SUM_W-1:0]       w_step_sum;
    logic        [SUM_W-RECUR_W:0] w_step_top;
    logic signed [RECUR_W-1:0]     w_step_sat;
    logic signed [SUM_W-1:0]       w_out_sum;
    logic        [SUM_W-OUT_W:0]   w_out_top;
    logic                          w_out_fits;
    logic        [OUT_W-1:0]       w_out_sat;

    assign w_prod     = r_x * r_b1;
    assign w_prod_ext = SUM_W'(w_prod);

    // In trig mode harmonics with n mod 4 equal to 3 enter with their sign flipped.
    assign w_flip     = (r_basis_mode == BASIS_TRIG) && ((int'(r_k) % 4) == 3);
    assign w_coef_ext = SUM_W'($signed(w_rd_data));
    assign w_coef_q15 = (w_flip ? -w_coef_ext : w_coef_ext) <<< COEF_SHIFT;

    // b_k = round(2 x b_{k+1}) - b_{k+2} + c_k, saturated to the accumulator width.
    assign w_step_sum = ((w_prod_ext + SUM_W'(STEP_RND)) >>> STEP_SHIFT)
                        - SUM_W'(r_b2) + w_coef_q15;
    assign w_step_top = w_step_sum[SUM_W-1:RECUR_W-1];

    always_comb begin
        if ((&w_step_top) || !(|w_step_top)) begin
            w_step_sat = w_step_sum[RECUR_W-1:0];
        end else if (w_step_sum[SUM_W-1]) begin
            w_step_sat = {1'b1, {(RECUR_W - 1){1'b0}}};
        end else begin
            w_step_sat = {1'b0, {(RECUR_W - 1){1'b1}}};
        end
    end

    // y = round(x b_1) - b_2, saturated to Q8.15 with a flag.
    assign w_out_sum  = ((w_prod_ext + SUM_W'(OUT_RND)) >>> OUT_SHIFT) - SUM_W'(r_b2);
    assign w_out_top  = w_out_sum[SUM_W-1:OUT_W-1];
    assign w_out_fits = (&w_out_top) || !(|w_out_top);

    always_comb begin
        if (w_out_fits) begin
            w_out_sat = w_out_sum[OUT_W-1:0];
        end else if (w_out_sum[SUM_W-1]) begin
            w_out_sat = {1'b1, {(OUT_W - 1){1'b0}}};
        end else begin
            w_out_sat = {1'b0, {(OUT_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_eval) begin
            r_x  <= w_sample_in;
            r_b1 <= '0;
            r_b2 <= '0;
        end else if (w_step) begin
            r_b1 <= w_step_sat;
            r_b2 <= r_b1;
        end
    end

    // Output register: holds a finished word while the sink stalls, so the input side
    // is free to take writes meanwhile.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_data <= w_out_sat;
            r_out_clip <= !w_out_fits;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_clip;

endmodule

`default_nettype wire

// ===== rtl/core/cse_checker.sv =====
// Port-level checker for the Chebyshev series evaluator, attached by the bind below.
// Depends on cse_pkg and the assertion macros in chebyshev_series_evaluator_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "chebyshev_series_evaluator_assert.svh"

module cse_checker
    import cse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic                s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,
    input  logic                m_axis_tuser
);

    logic w_eval_accept;
    logic w_write_accept;

    assign w_eval_accept  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_EVAL);
    assign w_write_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_WRITE);

    // A stalled result word holds.
    `CSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

    // An evaluation occupies the block: no input word is taken in the next cycle.
    `CSE_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, w_eval_accept, !s_axis_tready, "input ready right after an evaluate word")

    // A coefficient write produces no result word.
    `CSE_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, w_write_accept && !m_axis_tvalid, !m_axis_tvalid, "result word appeared after a write word")

    // A clipped result sits at one of the two saturation limits.
    `CSE_ASSERT_NOW(a_clip_limit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[OUT_W-1:0] == {1'b0, {(OUT_W - 1){1'b1}}}) || (m_axis_tdata[OUT_W-1:0] == {1'b1, {(OUT_W - 1){1'b0}}}), "clipped result is not at a limit")

endmodule

bind chebyshev_series_evaluator cse_checker u_cse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/chebyshev_series_evaluator_tb.sv =====
// Self-checking testbench for the Chebyshev series evaluator: a directed table, then random
// coefficient bursts and evaluations under three idle profiles and several register settings.
// Depends on cse_pkg and the chebyshev_series_evaluator RTL only.
`timescale 1ns / 1ps

module chebyshev_series_evaluator_tb;
    import cse_pkg::*;

    localparam int MAX_HARM    = 64;
    localparam int IN_DATA_W   = 40;
    localparam int ACC_BITS    = 40;
    localparam int RES_BITS    = 24;
    localparam int AMP_TO_Q15  = 3;
    localparam int STEP_FRAC   = 14;
    localparam int OUT_FRAC    = 15;
    localparam longint ROUND_STEP = 64'sd1 <<< (STEP_FRAC - 1);
    localparam longint ROUND_OUT  = 64'sd1 <<< (OUT_FRAC - 1);
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTINGS_PER_PROFILE = 6;
    localparam int ITEMS_PER_SETTING    = 60;
    // A register index the block does not decode; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;

    typedef struct packed {
        logic [RES_BITS-1:0] sample_out;
        logic                clipped;
    } t_series;

    localparam t_series ZERO_RESULT = '0;

    typedef enum {ROW_WRITE, ROW_EVAL, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        int        arg_a;   // coefficient index, sample, or register index
        int        arg_b;   // coefficient value or register data
        bit        typed;
        t_series   want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow of the block's state as the predictor sees it.
    logic signed [15:0] coef_amp [MAX_HARM];
    logic [6:0]         harm_count = 7'd16;
    logic               basis = BASIS_TRIG;

    t_series   expected_results [$];
    t_stim_row directed_rows [$];
    int        mismatches = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    chebyshev_series_evaluator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_bits(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Clenshaw recurrence from the highest harmonic down, then y = x*b1 - b2.
    function automatic t_series eval_series(logic signed [15:0] x);
        longint  xs, b1, b2, t, c, y;
        int      n, k;
        t_series r;
        xs = x;
        n = (harm_count > MAX_HARM) ? MAX_HARM : int'(harm_count);
        b1 = 0;
        b2 = 0;
        for (k = n; k >= 1; k--) begin
            c = coef_amp[k-1];
            // Trig form: harmonics 3, 7, 11, ... enter with the opposite sign.
            if (basis == BASIS_TRIG && (k & 3) == 3) c = -c;
            t = ((xs * b1 + ROUND_STEP) >>> STEP_FRAC) - b2 + (c <<< AMP_TO_Q15);
            b2 = b1;
            b1 = clamp_bits(t, ACC_BITS);
        end
        y = ((xs * b1 + ROUND_OUT) >>> OUT_FRAC) - b2;
        r.sample_out = RES_BITS'(clamp_bits(y, RES_BITS));
        r.clipped = (clamp_bits(y, RES_BITS) != y);
        return r;
    endfunction

    // Mostly random, sometimes one of the Q0.15 / Q3.12 corner values.
    function automatic logic [15:0] pick_q15();
        case ($urandom_range(15))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_row(t_row_kind kind, int a, int b, bit typed, t_series want);
        t_stim_row row;
        row.kind = kind;
        row.arg_a = a;
        row.arg_b = b;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // Offer one input word, with random gaps ahead of it, and update the shadow on acceptance.
    task automatic push_word(logic req, logic [6:0] idx, logic [15:0] amp, logic [15:0] x,
                             bit typed, t_series want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {1'b0, x, amp, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (req == REQ_WRITE) begin
            if (idx >= 1 && idx <= MAX_HARM) coef_amp[idx-1] = amp;
        end else begin
            expected_results.push_back(typed ? want : eval_series(x));
        end
    endtask

    // Registers change only with the block idle: drain all results, then wait for any
    // word that is still in flight to finish.
    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (MAX_HARM + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HARMONIC_COUNT) harm_count = data;
        else if (idx == CFG_BASIS_MODE) basis = data[0];
    endtask

    // Random traffic: bursts of coefficient writes followed by evaluations, occasional
    // full sweeps of all harmonics (one amplitude, alternating signs, or random values),
    // and stray writes to indexes the block must ignore.
    task automatic run_setting(int budget);
        int          done;
        int          roll;
        int          i;
        int          pattern;
        int          nw;
        int          ne;
        logic [15:0] v;
        done = 0;
        while (done < budget) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                push_word(REQ_WRITE, ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(65, 127)),
                          16'($urandom), 16'($urandom), 1'b0, ZERO_RESULT);
                done += 1;
            end else if (roll < 12) begin
                v = ($urandom_range(1) == 0) ? 16'h7FFF : 16'h8000;
                pattern = $urandom_range(2);
                for (i = 1; i <= MAX_HARM; i++) begin
                    push_word(REQ_WRITE, 7'(i),
                              (pattern == 1 && i[0]) ? -v : (pattern == 2 ? pick_q15() : v),
                              16'($urandom), 1'b0, ZERO_RESULT);
                end
                done += MAX_HARM;
            end else begin
                nw = $urandom_range(6);
                ne = $urandom_range(1, 3);
                for (i = 0; i < nw; i++) begin
                    push_word(REQ_WRITE, 7'($urandom_range(1, MAX_HARM)), pick_q15(),
                              16'($urandom), 1'b0, ZERO_RESULT);
                end
                for (i = 0; i < ne; i++) begin
                    push_word(REQ_EVAL, 7'($urandom), 16'($urandom), pick_q15(),
                              1'b0, ZERO_RESULT);
                end
                done += nw + ne;
            end
        end
    endtask

    // Result checker; the ready line is re-rolled every cycle from the current idle profile.
    always @(posedge i_clk) begin
        t_series want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result word with none expected: sample_out %h clipped %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[RES_BITS-1:0] !== want.sample_out) begin
                    $display("%0t: sample_out expected %h, got %h",
                             $time, want.sample_out, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser !== want.clipped) begin
                    $display("%0t: clipped expected %b, got %b",
                             $time, want.clipped, m_axis_tuser);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int              p, s, r;
        logic [6:0]      cnt;
        logic            md;
        t_stim_row       row;
        for (r = 0; r < MAX_HARM; r++) coef_amp[r] = '0;

        // All coefficients are zero after reset, so these evaluations must give zero.
        add_row(ROW_EVAL, -32768, 0, 1'b1, ZERO_RESULT);
        add_row(ROW_EVAL, 32767, 0, 1'b1, ZERO_RESULT);
        // Indexes 0 and above 64 are dropped; the store stays all zero.
        add_row(ROW_WRITE, 0, 32767, 1'b0, ZERO_RESULT);
        add_row(ROW_WRITE, 65, -32768, 1'b0, ZERO_RESULT);
        add_row(ROW_WRITE, 127, 32767, 1'b0, ZERO_RESULT);
        add_row(ROW_EVAL, 32767, 0, 1'b1, ZERO_RESULT);
        add_row(ROW_WRITE, 1, 32767, 1'b0, ZERO_RESULT);
        add_row(ROW_WRITE, 3, -32768, 1'b0, ZERO_RESULT);
        add_row(ROW_WRITE, 16, 4096, 1'b0, ZERO_RESULT);
        add_row(ROW_WRITE, 64, 32767, 1'b0, ZERO_RESULT);
        add_row(ROW_EVAL, 32767, 0, 1'b0, ZERO_RESULT);
        add_row(ROW_EVAL, -32768, 0, 1'b0, ZERO_RESULT);
        add_row(ROW_EVAL, 0, 0, 1'b0, ZERO_RESULT);
        add_row(ROW_REG, CFG_BASIS_MODE, BASIS_PLAIN, 1'b0, ZERO_RESULT);
        add_row(ROW_EVAL, 32767, 0, 1'b0, ZERO_RESULT);
        // With no harmonics summed the result is zero and never clipped.
        add_row(ROW_REG, CFG_HARMONIC_COUNT, 0, 1'b0, ZERO_RESULT);
        add_row(ROW_EVAL, 12345, 0, 1'b1, ZERO_RESULT);
        // Counts above 64 behave as 64.
        add_row(ROW_REG, CFG_HARMONIC_COUNT, 127, 1'b0, ZERO_RESULT);
        add_row(ROW_EVAL, -32768, 0, 1'b0, ZERO_RESULT);
        add_row(ROW_REG, CFG_HARMONIC_COUNT, 64, 1'b0, ZERO_RESULT);
        add_row(ROW_REG, CFG_SPARE, 0, 1'b0, ZERO_RESULT);
        add_row(ROW_EVAL, 23170, 0, 1'b0, ZERO_RESULT);
        add_row(ROW_REG, CFG_BASIS_MODE, BASIS_TRIG, 1'b0, ZERO_RESULT);
        add_row(ROW_REG, CFG_HARMONIC_COUNT, 1, 1'b0, ZERO_RESULT);
        add_row(ROW_EVAL, 32767, 0, 1'b0, ZERO_RESULT);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle profiles: sender light / receiver heavy, then swapped, then none.
        for (p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 17 : (p == 1) ? 86 : 0;
            recv_idle_pct = (p == 0) ? 86 : (p == 1) ? 17 : 0;
            if (p == 0) begin
                foreach (directed_rows[r]) begin
                    row = directed_rows[r];
                    case (row.kind)
                        ROW_WRITE: push_word(REQ_WRITE, 7'(row.arg_a), 16'(row.arg_b),
                                             16'($urandom), 1'b0, ZERO_RESULT);
                        ROW_EVAL:  push_word(REQ_EVAL, 7'($urandom), 16'($urandom),
                                             16'(row.arg_a), row.typed, row.want);
                        default:   set_register(CFG_IDX_W'(row.arg_a), CFG_DATA_W'(row.arg_b));
                    endcase
                end
            end
            for (s = 0; s < SETTINGS_PER_PROFILE; s++) begin
                case (s)
                    0: begin cnt = 7'd16;  md = BASIS_TRIG;  end
                    1: begin cnt = 7'd64;  md = BASIS_PLAIN; end
                    2: begin cnt = 7'd0;   md = BASIS_TRIG;  end
                    3: begin cnt = 7'd127; md = BASIS_TRIG;  end
                    4: begin cnt = 7'd1;   md = BASIS_PLAIN; end
                    default: begin
                        cnt = 7'($urandom_range(0, 127));
                        md = 1'($urandom_range(1));
                    end
                endcase
                set_register(CFG_HARMONIC_COUNT, cnt);
                // Upper data bits of the mode register are don't-care; randomize them.
                set_register(CFG_BASIS_MODE, {6'($urandom), md});
                run_setting(ITEMS_PER_SETTING);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (MAX_HARM + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
